### rtl/efaf_pkg.sv
`default_nettype none
// ============================================================================
// efaf_pkg
// Shared types and constants for the frame admission filter.
// ============================================================================
package efaf_pkg;

    localparam int WORD_W       = 32;
    localparam int REG_W        = 16;
    localparam int WCOUNT_W     = 16;
    localparam int MAC_W        = 48;
    localparam int HDR_LEN      = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int HIT_COUNT_BITS = 16;

    localparam logic [REG_W-1:0] HIT_LIMIT_RST   = 16'd64;
    localparam logic [REG_W-1:0] BUF_CAP_RST     = 16'd1024;
    localparam logic [REG_W-1:0] BUF_FILL_RST    = 16'd512;

    localparam logic [7:0]  TPID_HI    = 8'h81;
    localparam logic [7:0]  TPID_LO    = 8'h00;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [2:0]  PCP_MIN    = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIT_LIMIT = 2'd0,
        CFG_BUF_CAP   = 2'd1,
        CFG_BUF_FILL  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] hit_limit;
        logic [REG_W-1:0] buffer_capacity;
        logic [REG_W-1:0] buffer_fill;
    } efaf_cfg_t;

    // Header summary of one finished frame
    typedef struct packed {
        logic [MAC_W-1:0]    src_mac;
        logic                has_tag;
        logic [2:0]          pcp;
        logic                dei;
        logic                type_ok;
        logic [WCOUNT_W-1:0] words;
    } efaf_frame_t;

endpackage
`default_nettype wire

### rtl/efaf_if.sv
`default_nettype none
// ============================================================================
// efaf_if
// Valid/ready channels: frame words in, verdicts out, register writes.
// ============================================================================
interface efaf_word_if;
    logic                          valid;
    logic                          ready;
    logic [efaf_pkg::WORD_W-1:0]   word_data;
    logic                          word_last;

    modport source (output valid, output word_data, output word_last, input ready);
    modport sink   (input valid, input word_data, input word_last, output ready);
endinterface

interface efaf_result_if;
    logic                          valid;
    logic                          ready;
    logic                          forward;
    logic [efaf_pkg::WCOUNT_W-1:0] frame_words;

    modport source (output valid, output forward, output frame_words, input ready);
    modport sink   (input valid, input forward, input frame_words, output ready);
endinterface

interface efaf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [efaf_pkg::CFG_IDX_W-1:0] index;
    logic [efaf_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/efaf_regs.sv
`default_nettype none
// ============================================================================
// efaf_regs
// Configuration register file; writes always accepted.
// ============================================================================
module efaf_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    efaf_cfg_if.sink            cfg,
    output efaf_pkg::efaf_cfg_t regs
);
    import efaf_pkg::*;

    efaf_cfg_t regs_reg;
    efaf_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HIT_LIMIT: regs_next.hit_limit       = cfg.data;
                CFG_BUF_CAP:   regs_next.buffer_capacity = cfg.data;
                CFG_BUF_FILL:  regs_next.buffer_fill     = cfg.data;
                default:       regs_next                 = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.hit_limit       <= HIT_LIMIT_RST;
            regs_reg.buffer_capacity <= BUF_CAP_RST;
            regs_reg.buffer_fill     <= BUF_FILL_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

### rtl/efaf_capture.sv
`default_nettype none
// ============================================================================
// efaf_capture
// Header capture and word count; registers a frame summary on the last word.
// ============================================================================
module efaf_capture (
    input  wire logic             clk,
    input  wire logic             rst_n,
    efaf_word_if.sink             word,
    input  wire logic             frame_take,
    output logic                  frame_valid,
    output efaf_pkg::efaf_frame_t frame
);
    import efaf_pkg::*;

    logic [7:0]          header_reg [HDR_LEN];
    logic [7:0]          hdr_merged [HDR_LEN];
    logic [WCOUNT_W-1:0] word_counter_reg;
    logic [WCOUNT_W-1:0] word_counter_next;
    logic [WCOUNT_W-1:0] words;
    logic                rec_valid_reg;
    efaf_frame_t         rec_reg;
    efaf_frame_t         rec_next;
    logic                accept;
    logic [15:0]         etype;

    assign word.ready  = !rec_valid_reg || frame_take;
    assign accept      = word.valid && word.ready;
    assign frame_valid = rec_valid_reg;
    assign frame       = rec_reg;

    // Each header octet comes from a fixed word and lane
    for (genvar b = 0; b < HDR_LEN; b++)
    begin : g_hdr
        localparam int WORD_IDX = b / 4;
        localparam int LANE     = b % 4;
        assign hdr_merged[b] = (word_counter_reg == WCOUNT_W'(WORD_IDX))
                             ? word.word_data[WORD_W-1-8*LANE -: 8]
                             : header_reg[b];
    end

    assign words = (word_counter_reg != {WCOUNT_W{1'b1}})
                 ? word_counter_reg + WCOUNT_W'(1) : word_counter_reg;
    assign word_counter_next = word.word_last ? '0 : words;

    always_comb
    begin
        rec_next.src_mac = {hdr_merged[6], hdr_merged[7], hdr_merged[8],
                            hdr_merged[9], hdr_merged[10], hdr_merged[11]};
        rec_next.has_tag = (hdr_merged[12] == TPID_HI) && (hdr_merged[13] == TPID_LO);
        etype            = rec_next.has_tag ? {hdr_merged[16], hdr_merged[17]}
                                            : {hdr_merged[12], hdr_merged[13]};
        rec_next.pcp     = hdr_merged[14][7:5];
        rec_next.dei     = hdr_merged[14][4];
        rec_next.type_ok = (etype == ETYPE_IPV4) || (etype == ETYPE_ARP);
        rec_next.words   = words;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < HDR_LEN; b++)
            begin
                header_reg[b] <= '0;
            end
            word_counter_reg <= '0;
            rec_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int b = 0; b < HDR_LEN; b++)
                begin
                    header_reg[b] <= hdr_merged[b];
                end
                word_counter_reg <= word_counter_next;
            end
            if (accept && word.word_last)
            begin
                rec_valid_reg <= 1'b1;
            end
            else if (frame_take)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && word.word_last)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule
`default_nettype wire

### rtl/efaf_decide.sv
`default_nettype none
// ============================================================================
// efaf_decide
// Heavy-hitter source tracker, tag pressure rules and result register.
// ============================================================================
module efaf_decide #(
    parameter int COUNT_BITS = efaf_pkg::HIT_COUNT_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             frame_valid,
    input  efaf_pkg::efaf_frame_t frame,
    input  efaf_pkg::efaf_cfg_t   regs,
    output logic                  frame_take,
    efaf_result_if.source         result
);
    import efaf_pkg::*;

    localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

    logic [MAC_W-1:0]      tracked_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic [COUNT_BITS-1:0] hit_inc;
    logic                  match;
    logic                  src_ok;
    logic [REG_W-1:0]      half_cap;
    logic [REG_W-1:0]      three_q_cap;
    logic                  tag_ok;
    logic                  out_valid_reg;
    logic                  forward_reg;
    logic [WCOUNT_W-1:0]   words_reg;

    assign frame_take = frame_valid && (!out_valid_reg || result.ready);

    assign match   = frame.src_mac == tracked_reg;
    assign hit_inc = (hit_count_reg != {COUNT_BITS{1'b1}})
                   ? hit_count_reg + COUNT_BITS'(1) : hit_count_reg;
    assign src_ok  = !match || (CMP_W'(hit_inc) < CMP_W'(regs.hit_limit));

    assign half_cap    = regs.buffer_capacity >> 1;
    assign three_q_cap = regs.buffer_capacity - (regs.buffer_capacity >> 2);
    assign tag_ok = !frame.has_tag
                 || !((frame.dei && (half_cap < regs.buffer_fill))
                   || ((frame.pcp < PCP_MIN) && (three_q_cap < regs.buffer_fill)));

    assign result.valid       = out_valid_reg;
    assign result.forward     = forward_reg;
    assign result.frame_words = words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg   <= '0;
            hit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_take)
            begin
                out_valid_reg <= 1'b1;
                if (match)
                begin
                    hit_count_reg <= hit_inc;
                end
                else if (hit_count_reg == '0)
                begin
                    tracked_reg <= frame.src_mac;
                end
                else
                begin
                    hit_count_reg <= hit_count_reg - COUNT_BITS'(1);
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            forward_reg <= src_ok && tag_ok && frame.type_ok;
            words_reg   <= frame.words;
        end
    end

endmodule
`default_nettype wire

### rtl/ethernet_frame_admission_filter.sv
`default_nettype none
// ============================================================================
// ethernet_frame_admission_filter
// Header-based admit/discard decision for a stream of 32-bit frame words.
// ============================================================================
// Throughput: one word per cycle while input is not stalled, frames back
//   to back, down to one-word frames. A verdict passes the frame summary
//   register, then the result register, after its last word is accepted.
// Reset: rst_n asynchronous, active low; header, counters and tracker go to
//   zero, registers to hit_limit 64, buffer_capacity 1024, buffer_fill 512.
module ethernet_frame_admission_filter #(
    parameter int COUNT_BITS = efaf_pkg::HIT_COUNT_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    efaf_word_if.sink     word,
    efaf_cfg_if.sink      cfg,
    efaf_result_if.source result
);
    import efaf_pkg::*;

    // Pipeline:
    //   capture - merges each word into the 18-octet header copy and counts
    //             words; on the last word it registers a compact summary
    //             (source MAC, tag flag, PCP/DEI, ethertype verdict, count).
    //   decide  - runs the source tracker against that summary, applies the
    //             buffer pressure rules to tagged frames and holds the
    //             verdict in the result register.
    // The summary register parts input from output, so words keep flowing
    // while a verdict waits; input stalls only when both are full.

    efaf_cfg_t   regs;
    efaf_frame_t frame;
    logic        frame_valid;
    logic        frame_take;

    efaf_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    efaf_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .word        (word),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    efaf_decide #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .regs        (regs),
        .frame_take  (frame_take),
        .result      (result)
    );

    // A last word always lands in the summary register
    a_last_to_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (word.valid && word.ready && word.word_last) |=> frame_valid)
        else $error("last word did not produce a frame summary");

    // A stalled summary keeps its contents
    a_summary_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_take) |=> (frame_valid && $stable(frame)))
        else $error("frame summary changed while stalled");

    // A summary taken is offered as a result next cycle
    a_take_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_take |=> (result.valid && (result.frame_words == $past(frame.words))))
        else $error("taken summary not presented as result");

endmodule
`default_nettype wire
